@@ design/mbp_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// MSB-first bit packer package
// Shared widths, constants and the queue entry type of the bit packer.
// ----------------------------------------------------------------------------
package mbp_pkg;

  localparam int MAX_FIELD_BITS = 32;
  localparam int FIELD_W        = 32;
  localparam int COUNT_W        = 6;
  localparam int PEND_W         = 7;
  localparam int CNT_W          = 3;
  localparam int BYTE_W         = 8;
  localparam int BUF_W          = FIELD_W + BYTE_W;
  localparam int TOTAL_W        = 6;
  localparam int IN_TDATA_W     = 40;

  typedef struct packed {
    logic               flush;
    logic [COUNT_W-1:0] count;
    logic [FIELD_W-1:0] bits;
  } mbp_item_t;

  typedef struct packed {
    logic push;
    logic pop;
  } mbp_q_ctrl_t;

  typedef struct packed {
    logic full;
    logic empty;
  } mbp_q_stat_t;

endpackage
`default_nettype wire

@@ design/mbp_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Bit packer front end
// Accepts input items, saturates the bit count, left-aligns the field bits and
// drops items that append nothing before passing them to the queue.
// ----------------------------------------------------------------------------
module mbp_front (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_tvalid,
  output logic                             in_tready,
  input  wire logic [mbp_pkg::FIELD_W-1:0] field_value,
  input  wire logic [mbp_pkg::COUNT_W-1:0] bit_count,
  input  wire logic                        flush,
  input  wire mbp_pkg::mbp_q_stat_t        q_stat,
  output logic                             push,
  output mbp_pkg::mbp_item_t               item
);
  import mbp_pkg::*;

  logic               fr_valid_r, fr_valid_nxt;
  mbp_item_t          fr_item_r, fr_item_nxt;
  logic               accept;
  logic               keep;
  logic [COUNT_W-1:0] count_sat;
  logic [COUNT_W-1:0] align_shift;

  assign in_tready = !fr_valid_r || !q_stat.full;
  assign accept    = in_tvalid && in_tready;
  assign push      = fr_valid_r && !q_stat.full;
  assign item      = fr_item_r;

  always_comb begin
    if ({1'b0, bit_count} > 7'(MAX_FIELD_BITS)) begin
      count_sat = COUNT_W'(MAX_FIELD_BITS);
    end else begin
      count_sat = bit_count;
    end
    align_shift       = COUNT_W'(FIELD_W) - count_sat;
    keep              = flush || (count_sat != '0);
    fr_item_nxt.flush = flush;
    fr_item_nxt.count = count_sat;
    fr_item_nxt.bits  = field_value << align_shift;
    fr_valid_nxt      = (fr_valid_r && q_stat.full) || (accept && keep);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fr_valid_r <= 1'b0;
    end else begin
      fr_valid_r <= fr_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && keep) begin
      fr_item_r <= fr_item_nxt;
    end
  end

endmodule
`default_nettype wire

@@ design/mbp_queue.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Bit packer item queue
// Two-entry queue that decouples the front end from the byte emitter.
// ----------------------------------------------------------------------------
module mbp_queue (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire mbp_pkg::mbp_q_ctrl_t ctrl,
  input  wire mbp_pkg::mbp_item_t   wr_item,
  output mbp_pkg::mbp_q_stat_t      stat,
  output mbp_pkg::mbp_item_t        rd_item
);
  import mbp_pkg::*;

  mbp_item_t  mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] fill_r, fill_nxt;
  logic       do_push;
  logic       do_pop;

  assign stat.full  = (fill_r == 2'd2);
  assign stat.empty = (fill_r == 2'd0);
  assign do_push    = ctrl.push && !stat.full;
  assign do_pop     = ctrl.pop && !stat.empty;
  assign rd_item    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? !rd_ptr_r : rd_ptr_r;
    fill_nxt   = fill_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_item;
    end
  end

endmodule
`default_nettype wire

@@ design/mbp_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Bit packer byte emitter
// Merges queued fields with the pending bits and emits completed bytes one
// per cycle while out_tready allows, through an output register.
// ----------------------------------------------------------------------------
module mbp_back (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire mbp_pkg::mbp_q_stat_t       q_stat,
  input  wire mbp_pkg::mbp_item_t         q_item,
  output logic                            pop,
  output logic                            out_tvalid,
  input  wire logic                       out_tready,
  output logic [mbp_pkg::BYTE_W-1:0]      out_byte,
  output logic                            out_last
);
  import mbp_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EMIT = 2'b10
  } mbp_state_t;

  mbp_state_t          state_r, state_nxt;
  logic [PEND_W-1:0]   pend_r, pend_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [BUF_W-1:0]    buf_r, buf_nxt;
  logic [TOTAL_W-1:0]  total_r, total_nxt;
  logic                ov_r, ov_nxt;
  logic [BYTE_W-1:0]   ob_r, ob_nxt;
  logic                ol_r, ol_nxt;
  logic [BUF_W-1:0]    pend_wide;
  logic [BUF_W-1:0]    new_wide;
  logic [BUF_W-1:0]    load_buf;
  logic [TOTAL_W-1:0]  load_total;
  logic                slot_free;
  logic                final_byte;

  assign out_tvalid = ov_r;
  assign out_byte   = ob_r;
  assign out_last   = ol_r;
  assign slot_free  = !ov_r || out_tready;
  assign pop        = (state_r == ST_IDLE) && !q_stat.empty;
  assign final_byte = (total_r < TOTAL_W'(2 * BYTE_W));

  always_comb begin
    pend_wide = {pend_r, {(BUF_W - PEND_W){1'b0}}};
    new_wide  = {q_item.bits, {BYTE_W{1'b0}}} >> cnt_r;
    if (q_item.flush) begin
      load_buf   = pend_wide;
      load_total = (cnt_r != '0) ? TOTAL_W'(BYTE_W) : '0;
    end else begin
      load_buf   = pend_wide | new_wide;
      load_total = TOTAL_W'(cnt_r) + q_item.count;
    end
  end

  always_comb begin
    state_nxt = state_r;
    pend_nxt  = pend_r;
    cnt_nxt   = cnt_r;
    buf_nxt   = buf_r;
    total_nxt = total_r;
    ov_nxt    = ov_r && !out_tready;
    ob_nxt    = ob_r;
    ol_nxt    = ol_r;
    case (state_r)
      ST_IDLE: begin
        if (pop) begin
          buf_nxt   = load_buf;
          total_nxt = load_total;
          if (load_total >= TOTAL_W'(BYTE_W)) begin
            state_nxt = ST_EMIT;
          end else begin
            pend_nxt = load_buf[BUF_W-1 -: PEND_W];
            cnt_nxt  = load_total[CNT_W-1:0];
          end
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          ov_nxt    = 1'b1;
          ob_nxt    = buf_r[BUF_W-1 -: BYTE_W];
          ol_nxt    = final_byte;
          buf_nxt   = buf_r << BYTE_W;
          total_nxt = total_r - TOTAL_W'(BYTE_W);
          if (final_byte) begin
            pend_nxt  = buf_r[BUF_W-BYTE_W-1 -: PEND_W];
            cnt_nxt   = total_r[CNT_W-1:0];
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      pend_r  <= '0;
      cnt_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pend_r  <= pend_nxt;
      cnt_r   <= cnt_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    buf_r   <= buf_nxt;
    total_r <= total_nxt;
    ob_r    <= ob_nxt;
    ol_r    <= ol_nxt;
  end

endmodule
`default_nettype wire

@@ design/msb_first_bit_packer_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// MSB-first bit packer
// Appends variable-length bit fields to a byte stream, most significant bit
// first, and emits each completed byte with a last flag per input transfer.
// ----------------------------------------------------------------------------
// An input transfer carries up to 32 bits (the count saturates at 32) or a
// flush request that pads a partial byte with zeros. The front end registers
// each transfer into a two-entry queue; the emitter takes one queued item at a
// time and sends one byte per cycle while out_tready allows, and takes no new
// item until the last byte of the current one is in the output register. A
// zero-count item without flush is dropped by the front end. The last byte of
// each item carries out_tlast.
module msb_first_bit_packer_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [39:0] in_tdata,   // field_value[31:0], bit_count[37:32], zero pad
  input  wire logic        in_tuser,   // flush
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata,  // out_byte[7:0]
  output logic             out_tlast
);
  import mbp_pkg::*;

  mbp_q_ctrl_t q_ctrl;
  mbp_q_stat_t q_stat;
  mbp_item_t   fr_item;
  mbp_item_t   q_item;
  logic        fr_push;
  logic        bk_pop;

  assign q_ctrl.push = fr_push;
  assign q_ctrl.pop  = bk_pop;

  mbp_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .field_value (in_tdata[FIELD_W-1:0]),
    .bit_count   (in_tdata[FIELD_W +: COUNT_W]),
    .flush       (in_tuser),
    .q_stat      (q_stat),
    .push        (fr_push),
    .item        (fr_item)
  );

  mbp_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (q_ctrl),
    .wr_item (fr_item),
    .stat    (q_stat),
    .rd_item (q_item)
  );

  mbp_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_stat     (q_stat),
    .q_item     (q_item),
    .pop        (bk_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_byte   (out_tdata),
    .out_last   (out_tlast)
  );

endmodule
`default_nettype wire
